>>> src/coolant_fault_monitor_defines.svh
// Assertion macros used by the checker file cfm_checker.sv.
`ifndef COOLANT_FAULT_MONITOR_DEFINES_SVH
`define COOLANT_FAULT_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cfm_pkg.sv
package cfm_pkg;

  localparam int TEMP_W   = 12;
  localparam int PRESS_W  = 10;
  localparam int FLOW_W   = 12;
  localparam int PUMP_W   = 10;
  localparam int DELTA_W  = 11;
  localparam int CNT_W    = 8;
  localparam int RSN_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // reason bit positions
  localparam int RSN_INLET     = 0;
  localparam int RSN_OUTLET    = 1;
  localparam int RSN_PRESSURE  = 2;
  localparam int RSN_STALE     = 3;
  localparam int RSN_OVERTEMP  = 4;
  localparam int RSN_DELTA     = 5;
  localparam int RSN_LOWFLOW   = 6;
  localparam int RSN_OVERPRESS = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FLUID   = 3'd0,
    CFG_CLEAR_FLUID = 3'd1,
    CFG_MIN_FLOW    = 3'd2,
    CFG_MAX_PRESS   = 3'd3,
    CFG_MAX_DELTA   = 3'd4,
    CFG_TRIP        = 3'd5,
    CFG_CLEAR       = 3'd6,
    CFG_STARTUP     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  max_fluid;
    logic [TEMP_W-1:0]  clear_fluid;
    logic [FLOW_W-1:0]  min_flow;
    logic [PRESS_W-1:0] max_press;
    logic [DELTA_W-1:0] max_delta;
    logic [CNT_W-1:0]   trip_samples;
    logic [CNT_W-1:0]   clear_samples;
    logic [CNT_W-1:0]   startup_samples;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_fluid:       12'd850,
    clear_fluid:     12'd800,
    min_flow:        12'd500,
    max_press:       10'd400,
    max_delta:       11'd250,
    trip_samples:    8'd3,
    clear_samples:   8'd10,
    startup_samples: 8'd25
  };

  typedef struct packed {
    logic [TEMP_W-1:0]  inlet_temp;
    logic               inlet_ok;
    logic [TEMP_W-1:0]  outlet_temp;
    logic               outlet_ok;
    logic [PRESS_W-1:0] pressure_reading;
    logic               pressure_ok;
    logic [FLOW_W-1:0]  flow_reading;
    logic               flow_ok;
    logic [PUMP_W-1:0]  pump_demand;
    logic               pump_demand_ok;
  } sample_t;

  // fault history that feeds the over-temperature hold
  typedef struct packed {
    logic fault;
    logic overtemp_latched;
  } hist_t;

endpackage

>>> src/cfm_if.sv
interface cfm_in_if import cfm_pkg::*;;
  logic               valid;
  logic               ready;
  logic signed [TEMP_W-1:0] inlet_temp;
  logic               inlet_ok;
  logic signed [TEMP_W-1:0] outlet_temp;
  logic               outlet_ok;
  logic [PRESS_W-1:0] pressure_reading;
  logic               pressure_ok;
  logic [FLOW_W-1:0]  flow_reading;
  logic               flow_ok;
  logic [PUMP_W-1:0]  pump_demand;
  logic               pump_demand_ok;

  modport source (
    output valid, inlet_temp, inlet_ok, outlet_temp, outlet_ok, pressure_reading,
           pressure_ok, flow_reading, flow_ok, pump_demand, pump_demand_ok,
    input  ready
  );
  modport sink (
    input  valid, inlet_temp, inlet_ok, outlet_temp, outlet_ok, pressure_reading,
           pressure_ok, flow_reading, flow_ok, pump_demand, pump_demand_ok,
    output ready
  );
endinterface

interface cfm_out_if import cfm_pkg::*;;
  logic             valid;
  logic             ready;
  logic             fault_active;
  logic [RSN_W-1:0] latched_reasons;
  logic [RSN_W-1:0] sample_reasons;

  modport source (
    output valid, fault_active, latched_reasons, sample_reasons,
    input  ready
  );
  modport sink (
    input  valid, fault_active, latched_reasons, sample_reasons,
    output ready
  );
endinterface

>>> src/coolant_fault_monitor.sv
// Channel | Dir | Beat contents
// in_ch   | in  | temperatures, pressure, flow, pump command, each with its ok flag
// out_ch  | out | fault_active, latched_reasons, sample_reasons
// cfg_*   | in  | register index and write data, one write per cycle with cfg_we
//
// Takes one beat per clock unless the result stalls; each beat passes through the sample and result registers.
// Stage one registers the sample; stage two evaluates reasons against the run
// counters and latches and updates them in the same cycle as the result register.
// A stalled result holds stage two; the input stage still takes a beat if empty.
// Reset restores the default thresholds and clears all counters and latches.
module coolant_fault_monitor import cfm_pkg::*; #(
  parameter int unsigned PUMP_ON_TENTHS = 200
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cfm_in_if.sink                in_ch,
  cfm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t             cfg_r, cfg_nxt;
  sample_t          s1_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_fault_r;
  logic [RSN_W-1:0] out_latched_r;
  logic [RSN_W-1:0] out_sample_r;

  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0] bad_r, bad_nxt;
  logic [CNT_W-1:0] good_r, good_nxt;
  logic             fault_r, fault_nxt;
  logic [RSN_W-1:0] latch_r, latch_nxt;

  logic             advance;
  logic             consume;
  logic             take_in;
  logic [RSN_W-1:0] rsn;
  hist_t            hist;

  assign advance = !out_valid_r || out_ch.ready;
  assign consume = s1_valid_r && advance;
  assign take_in = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.fault_active    = out_fault_r;
  assign out_ch.latched_reasons = out_latched_r;
  assign out_ch.sample_reasons  = out_sample_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_FLUID:   cfg_nxt.max_fluid       = cfg_wdata[TEMP_W-1:0];
        CFG_CLEAR_FLUID: cfg_nxt.clear_fluid     = cfg_wdata[TEMP_W-1:0];
        CFG_MIN_FLOW:    cfg_nxt.min_flow        = cfg_wdata[FLOW_W-1:0];
        CFG_MAX_PRESS:   cfg_nxt.max_press       = cfg_wdata[PRESS_W-1:0];
        CFG_MAX_DELTA:   cfg_nxt.max_delta       = cfg_wdata[DELTA_W-1:0];
        CFG_TRIP:        cfg_nxt.trip_samples    = cfg_wdata[CNT_W-1:0];
        CFG_CLEAR:       cfg_nxt.clear_samples   = cfg_wdata[CNT_W-1:0];
        CFG_STARTUP:     cfg_nxt.startup_samples = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign hist = '{fault: fault_r, overtemp_latched: latch_r[RSN_OVERTEMP]};

  cfm_reasons #(
    .PUMP_ON_TENTHS(PUMP_ON_TENTHS)
  ) u_reasons (
    .smp      (s1_r),
    .cfg      (cfg_r),
    .seen_nxt (seen_nxt),
    .hist     (hist),
    .rsn      (rsn)
  );

  always_comb begin
    seen_nxt  = (seen_r == '1) ? seen_r : seen_r + CNT_W'(1);
    bad_nxt   = bad_r;
    good_nxt  = good_r;
    fault_nxt = fault_r;
    latch_nxt = latch_r;
    if (rsn != '0) begin
      good_nxt  = '0;
      bad_nxt   = (bad_r == '1) ? bad_r : bad_r + CNT_W'(1);
      latch_nxt = latch_r | rsn;
      if (bad_nxt >= cfg_r.trip_samples) begin
        fault_nxt = 1'b1;
      end
    end else begin
      bad_nxt  = '0;
      good_nxt = (good_r == '1) ? good_r : good_r + CNT_W'(1);
      if (good_nxt >= cfg_r.clear_samples) begin
        fault_nxt = 1'b0;
        latch_nxt = '0;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take_in) begin
      s1_valid_nxt = 1'b1;
    end else if (consume) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      bad_r       <= '0;
      good_r      <= '0;
      fault_r     <= 1'b0;
      latch_r     <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (consume) begin
        seen_r  <= seen_nxt;
        bad_r   <= bad_nxt;
        good_r  <= good_nxt;
        fault_r <= fault_nxt;
        latch_r <= latch_nxt;
      end
    end
  end

  // payload: hold until the stage moves
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_r <= '{
        inlet_temp:       in_ch.inlet_temp,
        inlet_ok:         in_ch.inlet_ok,
        outlet_temp:      in_ch.outlet_temp,
        outlet_ok:        in_ch.outlet_ok,
        pressure_reading: in_ch.pressure_reading,
        pressure_ok:      in_ch.pressure_ok,
        flow_reading:     in_ch.flow_reading,
        flow_ok:          in_ch.flow_ok,
        pump_demand:      in_ch.pump_demand,
        pump_demand_ok:   in_ch.pump_demand_ok
      };
    end
    if (consume) begin
      out_fault_r   <= fault_nxt;
      out_latched_r <= latch_nxt;
      out_sample_r  <= rsn;
    end
  end

endmodule

>>> src/cfm_reasons.sv
module cfm_reasons import cfm_pkg::*; #(
  parameter int unsigned PUMP_ON_TENTHS = 200
) (
  input  sample_t          smp,
  input  cfg_t             cfg,
  input  logic [CNT_W-1:0] seen_nxt,
  input  hist_t            hist,
  output logic [RSN_W-1:0] rsn
);

  logic signed [TEMP_W-1:0] t_in;
  logic signed [TEMP_W-1:0] t_out;
  logic signed [TEMP_W-1:0] t_hi;
  logic signed [TEMP_W-1:0] max_fluid;
  logic signed [TEMP_W-1:0] clear_fluid;
  logic signed [TEMP_W:0]   diff;
  logic [TEMP_W-1:0]        adiff;
  logic                     both_ok;
  logic                     flow_checks;
  logic                     otemp_trip;
  logic                     otemp_hold;

  always_comb begin
    t_in        = $signed(smp.inlet_temp);
    t_out       = $signed(smp.outlet_temp);
    max_fluid   = $signed(cfg.max_fluid);
    clear_fluid = $signed(cfg.clear_fluid);
    both_ok     = smp.inlet_ok && smp.outlet_ok;
    t_hi        = (t_in > t_out) ? t_in : t_out;
    diff        = $signed({t_in[TEMP_W-1], t_in}) - $signed({t_out[TEMP_W-1], t_out});
    adiff       = diff[TEMP_W] ? TEMP_W'(-diff) : TEMP_W'(diff);

    flow_checks = (seen_nxt >= cfg.startup_samples) && smp.pump_demand_ok &&
                  (smp.pump_demand >= PUMP_W'(PUMP_ON_TENTHS));

    otemp_trip  = both_ok && (t_hi >= max_fluid);
    otemp_hold  = hist.fault && hist.overtemp_latched && both_ok &&
                  ((t_in > clear_fluid) || (t_out > clear_fluid));

    rsn                = '0;
    rsn[RSN_INLET]     = !smp.inlet_ok;
    rsn[RSN_OUTLET]    = !smp.outlet_ok;
    rsn[RSN_PRESSURE]  = !smp.pressure_ok;
    rsn[RSN_STALE]     = flow_checks && !smp.flow_ok;
    rsn[RSN_OVERTEMP]  = otemp_trip || otemp_hold;
    rsn[RSN_DELTA]     = both_ok && (adiff >= {1'b0, cfg.max_delta});
    rsn[RSN_LOWFLOW]   = flow_checks && smp.flow_ok && (smp.flow_reading < cfg.min_flow);
    rsn[RSN_OVERPRESS] = smp.pressure_ok && (smp.pressure_reading > cfg.max_press);
  end

endmodule

>>> src/cfm_checker.sv
`include "coolant_fault_monitor_defines.svh"

module cfm_checker import cfm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             fault_active,
  input logic [RSN_W-1:0] latched_reasons,
  input logic [RSN_W-1:0] sample_reasons
);

  `CFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_reasons) && $stable(latched_reasons) && $stable(fault_active), "stalled result beat changed")
  `CFM_ASSERT_NOW(a_fault_has_reason, out_valid && fault_active, latched_reasons != '0, "fault without latched reason")
  `CFM_ASSERT_NOW(a_sample_in_latch, out_valid, (latched_reasons & sample_reasons) == sample_reasons, "sample reason missing from latch")
  `CFM_ASSERT_NEXT(a_in_reaches_out, (in_valid && in_ready) ##1 out_ready, out_valid, "accepted beat did not reach output")

endmodule

bind coolant_fault_monitor cfm_checker u_cfm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .fault_active    (out_ch.fault_active),
  .latched_reasons (out_ch.latched_reasons),
  .sample_reasons  (out_ch.sample_reasons)
);
